FILE: src/hsva_pkg.sv
// ----------------------------------------------------------------------------
// HSV to ARGB conversion package
// Shared widths, constants and types of the HSV to ARGB conversion core.
// ----------------------------------------------------------------------------
package hsva_pkg;

   // Field widths fixed by the interface.
   localparam int HUE_W  = 13;
   localparam int SV_W   = 9;
   localparam int WORD_W = 32;
   localparam int CHAN_W = 8;

   // Default fixed-point formats.
   localparam int HUE_FRAC_BITS_DEF = 4;
   localparam int UNIT_BITS_DEF     = 8;

   // Degrees in one hue sector.
   localparam int SECTOR_DEG = 60;

   localparam logic [CHAN_W-1:0] ALPHA_ONE = 8'h01;
   localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hff;

   // The secondary channel is divided by 60 in two steps: a two-bit shift and
   // a division by 15, done as a multiplication by ceil(2^16 / 15). The
   // reciprocal is exact for every quotient below 3840, which is also where
   // the channel saturates.
   localparam int XA_W        = 12;
   localparam int XA_LIMIT    = 3840;
   localparam int DIV15_W     = 13;
   localparam int DIV15_SHIFT = 16;
   localparam logic [DIV15_W-1:0] DIV15_MUL = 13'd4370;

   typedef enum logic [2:0] {
      SECT_RED_YELLOW,
      SECT_YELLOW_GREEN,
      SECT_GREEN_CYAN,
      SECT_CYAN_BLUE,
      SECT_BLUE_MAGENTA,
      SECT_MAGENTA_RED
   } sector_type;

   // Load enables of the five datapath register stages.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

FILE: src/hsva_datapath.sv
// ----------------------------------------------------------------------------
// HSV to ARGB datapath
// Five register stages: sector decode, products, channel scaling, secondary
// channel scaling, and channel ordering with word packing.
// ----------------------------------------------------------------------------
module hsva_datapath #(
   parameter int HUE_FRAC_BITS = hsva_pkg::HUE_FRAC_BITS_DEF,
   parameter int UNIT_BITS     = hsva_pkg::UNIT_BITS_DEF
) (
   input  logic                        clock,
   input  hsva_pkg::stage_en_type      stage_en,
   input  logic [hsva_pkg::HUE_W-1:0]  hue,
   input  logic [hsva_pkg::SV_W-1:0]   saturation,
   input  logic [hsva_pkg::SV_W-1:0]   brightness,
   output logic [hsva_pkg::WORD_W-1:0] color_word
);

   localparam int HW  = (HUE_FRAC_BITS + 9 < hsva_pkg::HUE_W) ?
                        HUE_FRAC_BITS + 9 : hsva_pkg::HUE_W;
   localparam int SW  = (UNIT_BITS + 1 < hsva_pkg::SV_W) ? UNIT_BITS + 1 : hsva_pkg::SV_W;
   localparam int HCW = HUE_FRAC_BITS + 10;
   localparam int P   = hsva_pkg::SECTOR_DEG << HUE_FRAC_BITS;
   localparam int U   = 1 << UNIT_BITS;
   localparam int UP  = P << UNIT_BITS;
   localparam int TW  = HUE_FRAC_BITS + 7;
   localparam int DW  = HUE_FRAC_BITS + 6;
   localparam int SDW = SW + DW;
   localparam int MW  = UNIT_BITS + 2;
   localparam int VSW = SW + 1 + MW;
   localparam int MPW = VSW + 8;
   localparam int CPW = SW + 8;
   localparam int EW  = HUE_FRAC_BITS + UNIT_BITS + 8;
   localparam int VEW = SW + 1 + EW;
   localparam int NW  = VEW + 8;
   localparam int XSH = 2 * UNIT_BITS + HUE_FRAC_BITS + 2;
   localparam int QW  = hsva_pkg::XA_W + hsva_pkg::DIV15_W;
   localparam int CW  = hsva_pkg::CHAN_W;

   // ---------------- Stage 1: sector decode ----------------
   logic [HCW-1:0]       h_x;
   logic [HCW-1:0]       base_x;
   logic                 oor_s1_in;
   hsva_pkg::sector_type sect_s1_in;

   logic                 oor_s1_ff;
   hsva_pkg::sector_type sect_s1_ff;
   logic [TW-1:0]        t_s1_ff;
   logic [SW-1:0]        sat_s1_ff;
   logic [SW-1:0]        bri_s1_ff;

   always_comb begin
      h_x       = HCW'(hue[HW-1:0]);
      oor_s1_in = (h_x > HCW'(6 * P));
      // Each sector owns its upper bound.
      if (h_x <= HCW'(P)) begin
         sect_s1_in = hsva_pkg::SECT_RED_YELLOW;
      end else if (h_x <= HCW'(2 * P)) begin
         sect_s1_in = hsva_pkg::SECT_YELLOW_GREEN;
      end else if (h_x <= HCW'(3 * P)) begin
         sect_s1_in = hsva_pkg::SECT_GREEN_CYAN;
      end else if (h_x <= HCW'(4 * P)) begin
         sect_s1_in = hsva_pkg::SECT_CYAN_BLUE;
      end else if (h_x <= HCW'(5 * P)) begin
         sect_s1_in = hsva_pkg::SECT_BLUE_MAGENTA;
      end else begin
         sect_s1_in = hsva_pkg::SECT_MAGENTA_RED;
      end
      // A hue on an even sector boundary lands at 2P instead of 0 here;
      // both give the same distance from P.
      if (h_x <= HCW'(2 * P)) begin
         base_x = '0;
      end else if (h_x <= HCW'(4 * P)) begin
         base_x = HCW'(2 * P);
      end else begin
         base_x = HCW'(4 * P);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         oor_s1_ff  <= oor_s1_in;
         sect_s1_ff <= sect_s1_in;
         t_s1_ff    <= TW'(h_x - base_x);
         sat_s1_ff  <= saturation[SW-1:0];
         bri_s1_ff  <= brightness[SW-1:0];
      end
   end

   // ---------------- Stage 2: products ----------------
   logic [DW-1:0]         hue_gap;
   logic [SDW-1:0]        sd_s2_in;
   logic signed [MW-1:0]  um;
   logic signed [VSW-1:0] vus_s2_in;
   logic [CPW-1:0]        cprod;
   logic [CPW-1:0]        cq;
   logic [CW-1:0]         cm_s2_in;

   logic                  oor_s2_ff;
   hsva_pkg::sector_type  sect_s2_ff;
   logic [SW-1:0]         bri_s2_ff;
   logic [SDW-1:0]        sd_s2_ff;
   logic signed [VSW-1:0] vus_s2_ff;
   logic [CW-1:0]         cm_s2_ff;

   always_comb begin
      hue_gap = (t_s1_ff >= TW'(P)) ? DW'(t_s1_ff - TW'(P)) : DW'(TW'(P) - t_s1_ff);
      sd_s2_in  = SDW'(sat_s1_ff) * SDW'(hue_gap);
      um        = MW'(U) - MW'(sat_s1_ff);
      vus_s2_in = VSW'($signed({1'b0, bri_s1_ff})) * VSW'(um);
      // The strongest channel is c + m = v.
      cprod     = CPW'(bri_s1_ff) * CPW'(255);
      cq        = cprod >> UNIT_BITS;
      cm_s2_in  = (cq > CPW'(255)) ? hsva_pkg::CHAN_MAX : cq[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         oor_s2_ff  <= oor_s1_ff;
         sect_s2_ff <= sect_s1_ff;
         bri_s2_ff  <= bri_s1_ff;
         sd_s2_ff   <= sd_s2_in;
         vus_s2_ff  <= vus_s2_in;
         cm_s2_ff   <= cm_s2_in;
      end
   end

   // ---------------- Stage 3: offset channel and secondary product ----------------
   logic signed [EW-1:0]  e_val;
   logic signed [VEW-1:0] ve_s3_in;
   logic signed [MPW-1:0] mprod;
   logic signed [MPW-1:0] mq;
   logic [CW-1:0]         mm_s3_in;

   logic                  oor_s3_ff;
   hsva_pkg::sector_type  sect_s3_ff;
   logic [CW-1:0]         cm_s3_ff;
   logic [CW-1:0]         mm_s3_ff;
   logic signed [VEW-1:0] ve_s3_ff;

   always_comb begin
      // x + m = v * (U*P - s*gap) over U*U*P.
      e_val    = EW'(UP) - EW'(sd_s2_ff);
      ve_s3_in = VEW'($signed({1'b0, bri_s2_ff})) * VEW'(e_val);
      mprod    = (MPW'(vus_s2_ff) <<< 8) - MPW'(vus_s2_ff);
      mq       = mprod >>> (2 * UNIT_BITS);
      if (mprod <= MPW'(0)) begin
         mm_s3_in = '0;
      end else if (mq > MPW'(255)) begin
         mm_s3_in = hsva_pkg::CHAN_MAX;
      end else begin
         mm_s3_in = mq[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         oor_s3_ff  <= oor_s2_ff;
         sect_s3_ff <= sect_s2_ff;
         cm_s3_ff   <= cm_s2_ff;
         mm_s3_ff   <= mm_s3_in;
         ve_s3_ff   <= ve_s3_in;
      end
   end

   // ---------------- Stage 4: secondary channel, power-of-two part ----------------
   logic signed [NW-1:0]        n_val;
   logic signed [NW-1:0]        a_val;
   logic [hsva_pkg::XA_W-1:0]   xa_s4_in;
   logic                        xsat_s4_in;

   logic                        oor_s4_ff;
   hsva_pkg::sector_type        sect_s4_ff;
   logic [CW-1:0]               cm_s4_ff;
   logic [CW-1:0]               mm_s4_ff;
   logic [hsva_pkg::XA_W-1:0]   xa_s4_ff;
   logic                        xsat_s4_ff;

   always_comb begin
      n_val = (NW'(ve_s3_ff) <<< 8) - NW'(ve_s3_ff);
      a_val = n_val >>> XSH;
      if (n_val <= NW'(0)) begin
         xa_s4_in   = '0;
         xsat_s4_in = 1'b0;
      end else if (a_val >= NW'(hsva_pkg::XA_LIMIT)) begin
         xa_s4_in   = '0;
         xsat_s4_in = 1'b1;
      end else begin
         xa_s4_in   = a_val[hsva_pkg::XA_W-1:0];
         xsat_s4_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s4) begin
         oor_s4_ff  <= oor_s3_ff;
         sect_s4_ff <= sect_s3_ff;
         cm_s4_ff   <= cm_s3_ff;
         mm_s4_ff   <= mm_s3_ff;
         xa_s4_ff   <= xa_s4_in;
         xsat_s4_ff <= xsat_s4_in;
      end
   end

   // ---------------- Stage 5: divide by 15, order channels, pack ----------------
   logic [QW-1:0]              qprod;
   logic [CW-1:0]              xm;
   logic [CW-1:0]              red;
   logic [CW-1:0]              green;
   logic [CW-1:0]              blue;
   logic [hsva_pkg::WORD_W-1:0] color_s5_in;
   logic [hsva_pkg::WORD_W-1:0] color_s5_ff;

   always_comb begin
      qprod = QW'(xa_s4_ff) * QW'(hsva_pkg::DIV15_MUL);
      xm    = xsat_s4_ff ? hsva_pkg::CHAN_MAX : qprod[hsva_pkg::DIV15_SHIFT +: CW];
      case (sect_s4_ff)
         hsva_pkg::SECT_RED_YELLOW: begin
            red = cm_s4_ff; green = xm;       blue = mm_s4_ff;
         end
         hsva_pkg::SECT_YELLOW_GREEN: begin
            red = xm;       green = cm_s4_ff; blue = mm_s4_ff;
         end
         hsva_pkg::SECT_GREEN_CYAN: begin
            red = mm_s4_ff; green = cm_s4_ff; blue = xm;
         end
         hsva_pkg::SECT_CYAN_BLUE: begin
            red = mm_s4_ff; green = xm;       blue = cm_s4_ff;
         end
         hsva_pkg::SECT_BLUE_MAGENTA: begin
            red = xm;       green = mm_s4_ff; blue = cm_s4_ff;
         end
         default: begin
            red = cm_s4_ff; green = mm_s4_ff; blue = xm;
         end
      endcase
      color_s5_in = oor_s4_ff ? '0 : {hsva_pkg::ALPHA_ONE, red, green, blue};
   end

   always_ff @(posedge clock) begin
      if (stage_en.s5) begin
         color_s5_ff <= color_s5_in;
      end
   end

   assign color_word = color_s5_ff;

endmodule

FILE: src/hsv_to_argb_convert_core.sv
// ----------------------------------------------------------------------------
// HSV to ARGB conversion core
// Converts one pixel's hue, saturation and value into a packed ARGB word.
// ----------------------------------------------------------------------------
// The core takes one pixel word per clock unless a stall on the result side
// holds its input side, and returns one color word per pixel, in order. When
// the result side is not stalled, a pixel passes through the five register
// stages in order, the first of which loads at the accepting edge. The stages
// are sector decode, the saturation and offset products, the scaling of
// the strongest and weakest channels, the power-of-two part of the
// secondary channel scaling, and a reciprocal divide by 15 followed by
// channel ordering.
// Each stage holds its own valid bit, so a stall on the result side fills
// empty stages first and only then holds the input side; nothing is dropped
// or repeated. Hue is in 1/2^HUE_FRAC_BITS degree steps and saturation and
// value use 2^UNIT_BITS as 1.0. A hue beyond 360 degrees gives an all-zero
// word, alpha included; otherwise alpha reads 1 and each color channel is
// floor(255 * level), saturated to the 0..255 range.
module hsv_to_argb_convert_core #(
   parameter int HUE_FRAC_BITS = hsva_pkg::HUE_FRAC_BITS_DEF,
   parameter int UNIT_BITS     = hsva_pkg::UNIT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [hsva_pkg::HUE_W-1:0]  req_hue,
   input  logic [hsva_pkg::SV_W-1:0]   req_saturation,
   input  logic [hsva_pkg::SV_W-1:0]   req_brightness,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hsva_pkg::WORD_W-1:0] rsp_color_word
);

   localparam int NSTAGE = 5;

   // Valid bit of each register stage; the last one is the output word.
   logic [NSTAGE-1:0]      vld_ff;
   logic [NSTAGE-1:0]      vld_in;
   logic [NSTAGE-1:0]      stage_rdy;
   logic [NSTAGE-1:0]      vld_prev;
   hsva_pkg::stage_en_type stage_en;

   // A stage can load when it is empty or when the stage after it moves on.
   always_comb begin
      stage_rdy[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_rdy[k] = !vld_ff[k] || stage_rdy[k+1];
      end
      vld_prev = {vld_ff[NSTAGE-2:0], req_valid};
      for (int k = 0; k < NSTAGE; k++) begin
         vld_in[k] = stage_rdy[k] ? vld_prev[k] : vld_ff[k];
      end
      // Data registers only load when a real word moves in.
      stage_en.s1 = stage_rdy[0] && vld_prev[0];
      stage_en.s2 = stage_rdy[1] && vld_prev[1];
      stage_en.s3 = stage_rdy[2] && vld_prev[2];
      stage_en.s4 = stage_rdy[3] && vld_prev[3];
      stage_en.s5 = stage_rdy[4] && vld_prev[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = stage_rdy[0];
   assign rsp_valid = vld_ff[NSTAGE-1];

   hsva_datapath #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .UNIT_BITS     (UNIT_BITS)
   ) u_datapath (
      .clock      (clock),
      .stage_en   (stage_en),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .color_word (rsp_color_word)
   );

endmodule

FILE: src/hsva_checker.sv
// ----------------------------------------------------------------------------
// HSV to ARGB port checker
// Port-level assertions for the HSV to ARGB conversion core.
// ----------------------------------------------------------------------------
module hsva_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [hsva_pkg::WORD_W-1:0] rsp_color_word
);

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color_word))
      else $error("result word changed or vanished while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // When the output moves, every stage can move, so the input is open.
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input held while the output side is free");

   // Every word is either all zero or carries an alpha of one.
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_color_word[31:24] == hsva_pkg::ALPHA_ONE) ||
                    (rsp_color_word == '0))
      else $error("bad alpha in result word");

   // A pixel word that is offered stays offered until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("pixel word withdrawn before it was taken");

endmodule

bind hsv_to_argb_convert_core hsva_checker u_hsva_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_color_word (rsp_color_word)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to ARGB conversion core testbench
// Feeds pixel words through the core with random idling on both handshakes.
// A scoreboard predicts every color word in exact integer arithmetic and
// compares the results in order.
// ----------------------------------------------------------------------------

class argb_scoreboard;

   localparam int HUE_FRAC = hsva_pkg::HUE_FRAC_BITS_DEF;
   localparam int UNIT_EXP = hsva_pkg::UNIT_BITS_DEF;
   localparam longint SECTOR_UNITS = longint'(hsva_pkg::SECTOR_DEG) << HUE_FRAC;
   localparam longint UNIT_ONE = longint'(1) << UNIT_EXP;
   localparam longint LEVEL_DEN = UNIT_ONE * UNIT_ONE * SECTOR_UNITS;

   logic [hsva_pkg::WORD_W-1:0] expected_words[$];
   int error_count = 0;

   // Channel level is floor(255 * num / den), clamped to 0..255.
   static function logic [hsva_pkg::CHAN_W-1:0] scale_channel(longint num);
      longint q;
      if (num <= 0) begin
         return '0;
      end
      q = (num * 255) / LEVEL_DEN;
      if (q > 255) begin
         return hsva_pkg::CHAN_MAX;
      end
      return q[hsva_pkg::CHAN_W-1:0];
   endfunction

   static function logic [hsva_pkg::WORD_W-1:0] argb_from_hsv(
      logic [hsva_pkg::HUE_W-1:0] hue,
      logic [hsva_pkg::SV_W-1:0]  sat,
      logic [hsva_pkg::SV_W-1:0]  val);
      longint h, s, v, vs, t, hue_gap, cn, xn, mn;
      logic [hsva_pkg::CHAN_W-1:0] top, mid, low, r, g, b;
      hsva_pkg::sector_type sect;
      h = longint'(hue);
      s = longint'(sat);
      v = longint'(val);
      if (h > 6 * SECTOR_UNITS) begin
         return '0;
      end
      vs = v * s;
      t = h % (2 * SECTOR_UNITS);
      hue_gap = t - SECTOR_UNITS;
      if (hue_gap < 0) begin
         hue_gap = -hue_gap;
      end
      cn = vs * SECTOR_UNITS;
      xn = vs * (SECTOR_UNITS - hue_gap);
      mn = (v * UNIT_ONE - vs) * SECTOR_UNITS;
      top = scale_channel(cn + mn);
      mid = scale_channel(xn + mn);
      low = scale_channel(mn);
      // Each sector owns its upper bound.
      if (h <= SECTOR_UNITS) begin
         sect = hsva_pkg::SECT_RED_YELLOW;
      end else if (h <= 2 * SECTOR_UNITS) begin
         sect = hsva_pkg::SECT_YELLOW_GREEN;
      end else if (h <= 3 * SECTOR_UNITS) begin
         sect = hsva_pkg::SECT_GREEN_CYAN;
      end else if (h <= 4 * SECTOR_UNITS) begin
         sect = hsva_pkg::SECT_CYAN_BLUE;
      end else if (h <= 5 * SECTOR_UNITS) begin
         sect = hsva_pkg::SECT_BLUE_MAGENTA;
      end else begin
         sect = hsva_pkg::SECT_MAGENTA_RED;
      end
      case (sect)
         hsva_pkg::SECT_RED_YELLOW: begin
            r = top; g = mid; b = low;
         end
         hsva_pkg::SECT_YELLOW_GREEN: begin
            r = mid; g = top; b = low;
         end
         hsva_pkg::SECT_GREEN_CYAN: begin
            r = low; g = top; b = mid;
         end
         hsva_pkg::SECT_CYAN_BLUE: begin
            r = low; g = mid; b = top;
         end
         hsva_pkg::SECT_BLUE_MAGENTA: begin
            r = mid; g = low; b = top;
         end
         default: begin
            r = top; g = low; b = mid;
         end
      endcase
      return {hsva_pkg::ALPHA_ONE, r, g, b};
   endfunction

   function void note_pixel(logic [hsva_pkg::HUE_W-1:0] hue,
                            logic [hsva_pkg::SV_W-1:0]  sat,
                            logic [hsva_pkg::SV_W-1:0]  val);
      expected_words.push_back(argb_from_hsv(hue, sat, val));
   endfunction

   function void check_word(logic [hsva_pkg::WORD_W-1:0] actual);
      logic [hsva_pkg::WORD_W-1:0] want;
      if (expected_words.size() == 0) begin
         $error("color_word: no word expected, actual %08h", actual);
         error_count++;
         return;
      end
      want = expected_words.pop_front();
      if (actual !== want) begin
         $error("color_word: expected %08h, actual %08h", want, actual);
         error_count++;
      end
   endfunction

   function int pending_count();
      return expected_words.size();
   endfunction

endclass

module tb_top;

   localparam int PIXEL_COUNT = 1950;
   // Hue units per 60-degree sector and the value that stands for 1.0.
   localparam int SECTOR_STEP = hsva_pkg::SECTOR_DEG << hsva_pkg::HUE_FRAC_BITS_DEF;
   localparam int UNIT_FULL = 1 << hsva_pkg::UNIT_BITS_DEF;
   // The core has five register stages; the tail wait leaves ample margin.
   localparam int DRAIN_CYCLES = 20;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [hsva_pkg::HUE_W-1:0]  req_hue;
   logic [hsva_pkg::SV_W-1:0]   req_saturation;
   logic [hsva_pkg::SV_W-1:0]   req_brightness;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [hsva_pkg::WORD_W-1:0] rsp_color_word;

   argb_scoreboard board = new();

   // While calm is set neither side idles, so the pipeline runs at full rate.
   logic calm;

   hsv_to_argb_convert_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_color_word (rsp_color_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hang guard, a few times the slowest legal run.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Idle lengths: most are zero or short, a few are long.
   function automatic int idle_length();
      int roll;
      if (calm) begin
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 65) begin
         return 0;
      end else if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Both handshakes are sampled at the rising edge, before any of this
   // edge's nonblocking updates land, so the monitor sees exactly the
   // values that the core used to decide on acceptance.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_pixel(req_hue, req_saturation, req_brightness);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_word(rsp_color_word);
         end
      end
   end

   // Result side: stalls of random length, with one cycle of ready at least
   // between them.
   initial begin
      int stall_left;
      stall_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = idle_length();
         end
      end
   end

   // Offers one pixel word after an optional gap and holds it until the
   // core takes it. The gap lowers valid in an earlier step than the one in
   // which it rises again, so valid never gets two updates in one step.
   // Field values are cut to the port widths here.
   task automatic send_pixel(input int hue,
                             input int sat,
                             input int val,
                             input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue[hsva_pkg::HUE_W-1:0];
      req_saturation <= sat[hsva_pkg::SV_W-1:0];
      req_brightness <= val[hsva_pkg::SV_W-1:0];
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Holds the input side until every predicted word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_count() != 0) begin
         @(posedge clock);
      end
   endtask

   // A random pixel. Most words are well formed, with hue within 360 degrees
   // and saturation and value within 1.0. Some sit on or next to a sector
   // boundary, and the rest use the full width of every field.
   task automatic send_random_pixel();
      int roll;
      int hue;
      int sat;
      int val;
      roll = $urandom_range(99);
      if (roll < 70) begin
         hue = $urandom_range(0, 6 * SECTOR_STEP);
         sat = $urandom_range(0, UNIT_FULL);
         val = $urandom_range(0, UNIT_FULL);
      end else if (roll < 82) begin
         hue = $urandom_range(0, 6) * SECTOR_STEP + $urandom_range(0, 2) - 1;
         sat = $urandom_range(0, UNIT_FULL);
         val = $urandom_range(0, UNIT_FULL);
      end else begin
         hue = $urandom;
         sat = $urandom;
         val = $urandom;
      end
      send_pixel(hue, sat, val, idle_length());
   endtask

   initial begin
      reset          = 1'b1;
      calm           = 1'b1;
      req_valid      = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_brightness = '0;
      rsp_ready      = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, back to back. Sector ends and the first hue past each
      // of them check that a boundary belongs to the lower sector.
      send_pixel(0, UNIT_FULL, UNIT_FULL, 0);
      send_pixel(SECTOR_STEP, UNIT_FULL, UNIT_FULL, 0);
      send_pixel(SECTOR_STEP + 1, UNIT_FULL, UNIT_FULL, 0);
      send_pixel(2 * SECTOR_STEP, UNIT_FULL, UNIT_FULL, 0);
      send_pixel(2 * SECTOR_STEP + 1, UNIT_FULL, 200, 0);
      send_pixel(3 * SECTOR_STEP, 200, UNIT_FULL, 0);
      send_pixel(3 * SECTOR_STEP + 1, UNIT_FULL, UNIT_FULL, 0);
      send_pixel(4 * SECTOR_STEP, UNIT_FULL, 128, 0);
      send_pixel(4 * SECTOR_STEP + 1, UNIT_FULL, UNIT_FULL, 0);
      send_pixel(5 * SECTOR_STEP, UNIT_FULL, UNIT_FULL, 0);
      send_pixel(5 * SECTOR_STEP + 1, 128, UNIT_FULL, 0);
      send_pixel(6 * SECTOR_STEP, UNIT_FULL, UNIT_FULL, 0);
      // Hue past 360 degrees gives an all-zero word, alpha included.
      send_pixel(6 * SECTOR_STEP + 1, UNIT_FULL, UNIT_FULL, 0);
      send_pixel('1, '1, '1, 0);
      // Grey and black corners.
      send_pixel(SECTOR_STEP / 2, 0, UNIT_FULL, 0);
      send_pixel(SECTOR_STEP / 2, UNIT_FULL, 0, 0);
      send_pixel(0, 0, 0, 0);
      // Value above 1.0 saturates the channels at 255.
      send_pixel(SECTOR_STEP / 2, 0, '1, 0);
      send_pixel(7 * SECTOR_STEP / 2, 100, '1, 0);
      // Saturation above 1.0 drives the weak channels below zero.
      send_pixel(SECTOR_STEP / 2, '1, UNIT_FULL, 0);
      send_pixel(9 * SECTOR_STEP / 2, '1, '1, 0);
      send_pixel(11 * SECTOR_STEP / 2, 300, 100, 0);
      send_pixel(6 * SECTOR_STEP - 1, 1, 1, 0);

      // The sender waits here until the pipeline is empty.
      drain_results();

      for (int i = 0; i < PIXEL_COUNT; i++) begin
         // Every few hundred words comes a stretch with no idling.
         calm = (i % 400) < 40;
         if (i == PIXEL_COUNT / 2) begin
            drain_results();
         end
         send_random_pixel();
      end

      // The last accepted pixel is noted by the monitor at the same edge, so
      // the wait checks the pending words from the next edge on.
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.pending_count() != 0) begin
         $error("color_word: %0d expected words never arrived", board.pending_count());
         board.error_count++;
      end
      if (board.error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
